// ===== rtl/core/urbc_pkg.sv =====
// Shared types and codes for the buffered UART ring controller.
// No dependencies; imported by uart_ring_buffer_controller_top.
`default_nettype none

package urbc_pkg;

  // request opcodes
  localparam logic [2:0] OP_HOST_WRITE = 3'd0;
  localparam logic [2:0] OP_HOST_READ  = 3'd1;
  localparam logic [2:0] OP_LINE_RX    = 3'd2;
  localparam logic [2:0] OP_TX_READY   = 3'd3;
  localparam logic [2:0] OP_RX_PURGE   = 3'd4;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 160;

  // result word, first declared member sits in the top bits
  typedef struct packed {
    logic        tx_irq_enabled;
    logic [31:0] overrun_errors;
    logic [31:0] noise_errors;
    logic [31:0] parity_errors;
    logic [31:0] framing_errors;
    logic [5:0]  rx_count;
    logic [5:0]  tx_free;
    logic [7:0]  line_send_byte;
    logic        line_send_valid;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        accepted;
  } urbc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/uart_ring_buffer_controller_top.sv =====
// Buffered UART ring controller: transmit and receive rings held in two
// synchronous byte memories, plus error counters. Depends on urbc_pkg.
//
// Usage:
//  - s_axis carries one request: tuser is the opcode (host write, host read,
//    line byte received, transmitter ready, purge receive ring); tdata holds
//    the byte and the four line error flags.
//  - m_axis returns exactly one result per request: flags, popped byte, the
//    byte for the transmitter, ring levels, error counts and the irq flag.
//  - cfg writes the echo enable bit; cfg_ready is always high.
//  - Each ring holds depth minus one bytes.
// Flow: an accepted request's ring memory read and response flags are
//  registered first, then the result goes into the output register and
//  m_axis_tvalid rises. No new request is taken while one is in flight.
// Reset (rst, synchronous): pointers and counters cleared, irq flag set,
//  echo off. Memory contents are left as they are.
// Stall: while a result is held and m_axis_tready is low, s_axis_tready
//  stays low; nothing is lost or repeated.
`default_nettype none

module uart_ring_buffer_controller_top
  import urbc_pkg::*;
#(
  parameter int unsigned TX_DEPTH = 64,
  parameter int unsigned RX_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [7:0] data_byte, [8] frame_error, [9] parity_error, [10] noise_error,
  // [11] overrun_error, [15:12] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  wire logic [2:0]             s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] accepted, [1] read_valid, [9:2] read_byte, [10] line_send_valid,
  // [18:11] line_send_byte, [24:19] tx_free, [30:25] rx_count,
  // [62:31] framing_errors, [94:63] parity_errors, [126:95] noise_errors,
  // [158:127] overrun_errors, [159] tx_irq_enabled
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic                   cfg_data
);

  localparam int unsigned TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
  localparam logic [TX_PW:0]   TX_SPAN = (TX_PW+1)'(TX_DEPTH);
  localparam logic [RX_PW:0]   RX_SPAN = (RX_PW+1)'(RX_DEPTH);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;

  logic [TX_PW-1:0] tx_write_ptr, tx_read_ptr;
  logic [RX_PW-1:0] rx_write_ptr, rx_read_ptr;
  logic [31:0]      frame_err_count, parity_err_count;
  logic [31:0]      noise_err_count, overrun_err_count;
  logic             tx_irq_flag;
  logic             echo_enable;
  logic             busy;

  // captured per request, consumed in the response cycle
  logic             resp_accepted;
  logic             resp_read;
  logic             resp_send_tx;
  logic             resp_send_echo;
  logic [7:0]       echo_byte;

  urbc_result_t     out_q;
  urbc_result_t     res;

  logic [2:0]       opcode;
  logic [7:0]       data_byte;
  logic             fe, pe, ne, oe, err_any;
  logic             in_acc;
  logic [TX_PW-1:0] tx_wr_inc, tx_rd_inc;
  logic [RX_PW-1:0] rx_wr_inc, rx_rd_inc;
  logic             tx_full, tx_empty, rx_full, rx_empty;
  logic [TX_PW:0]   tx_free_full;
  logic [RX_PW:0]   rx_count_full;

  assign opcode    = s_axis_tuser;
  assign data_byte = s_axis_tdata[7:0];
  assign fe        = s_axis_tdata[8];
  assign pe        = s_axis_tdata[9];
  assign ne        = s_axis_tdata[10];
  assign oe        = s_axis_tdata[11];
  assign err_any   = fe | pe | ne | oe;

  assign s_axis_tready = !busy && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = out_q;

  assign tx_wr_inc = (tx_write_ptr == TX_LAST) ? '0 : tx_write_ptr + 1'b1;
  assign tx_rd_inc = (tx_read_ptr == TX_LAST) ? '0 : tx_read_ptr + 1'b1;
  assign rx_wr_inc = (rx_write_ptr == RX_LAST) ? '0 : rx_write_ptr + 1'b1;
  assign rx_rd_inc = (rx_read_ptr == RX_LAST) ? '0 : rx_read_ptr + 1'b1;
  assign tx_full   = (tx_wr_inc == tx_read_ptr);
  assign tx_empty  = (tx_write_ptr == tx_read_ptr);
  assign rx_full   = (rx_wr_inc == rx_read_ptr);
  assign rx_empty  = (rx_write_ptr == rx_read_ptr);

  // ring levels, from the pointers as updated by the request in flight
  always_comb begin
    if (tx_read_ptr > tx_write_ptr) begin
      tx_free_full = {1'b0, tx_read_ptr} - {1'b0, tx_write_ptr} - 1'b1;
    end else begin
      tx_free_full = {1'b0, tx_read_ptr} + TX_SPAN - {1'b0, tx_write_ptr} - 1'b1;
    end
    if (rx_write_ptr >= rx_read_ptr) begin
      rx_count_full = {1'b0, rx_write_ptr} - {1'b0, rx_read_ptr};
    end else begin
      rx_count_full = {1'b0, rx_write_ptr} + RX_SPAN - {1'b0, rx_read_ptr};
    end
  end

  always_comb begin
    res.accepted        = resp_accepted;
    res.read_valid      = resp_read;
    res.read_byte       = resp_read ? rx_rdata : 8'd0;
    res.line_send_valid = resp_send_tx | resp_send_echo;
    res.line_send_byte  = resp_send_tx   ? tx_rdata :
                          resp_send_echo ? echo_byte : 8'd0;
    res.tx_free         = 6'(tx_free_full);
    res.rx_count        = 6'(rx_count_full);
    res.framing_errors  = frame_err_count;
    res.parity_errors   = parity_err_count;
    res.noise_errors    = noise_err_count;
    res.overrun_errors  = overrun_err_count;
    res.tx_irq_enabled  = tx_irq_flag;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_write_ptr      <= '0;
      tx_read_ptr       <= '0;
      rx_write_ptr      <= '0;
      rx_read_ptr       <= '0;
      frame_err_count   <= '0;
      parity_err_count  <= '0;
      noise_err_count   <= '0;
      overrun_err_count <= '0;
      tx_irq_flag       <= 1'b1;
      echo_enable       <= 1'b0;
      busy              <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        echo_enable <= cfg_data;
      end
      busy <= in_acc;
      if (busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_acc) begin
        unique case (opcode)
          OP_HOST_WRITE: begin
            if (!tx_full) begin
              tx_write_ptr <= tx_wr_inc;
              tx_irq_flag  <= 1'b1;
            end
          end
          OP_HOST_READ: begin
            if (!rx_empty) rx_read_ptr <= rx_rd_inc;
          end
          OP_LINE_RX: begin
            if (fe) frame_err_count   <= frame_err_count + 1'b1;
            if (pe) parity_err_count  <= parity_err_count + 1'b1;
            if (ne) noise_err_count   <= noise_err_count + 1'b1;
            if (oe) overrun_err_count <= overrun_err_count + 1'b1;
            if (!err_any && !rx_full) rx_write_ptr <= rx_wr_inc;
          end
          OP_TX_READY: begin
            if (tx_empty) begin
              tx_irq_flag <= 1'b0;
            end else begin
              tx_read_ptr <= tx_rd_inc;
            end
          end
          OP_RX_PURGE: begin
            rx_write_ptr <= '0;
            rx_read_ptr  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ring memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_HOST_WRITE && !tx_full) begin
      tx_mem[tx_write_ptr] <= data_byte;
    end
    if (in_acc && opcode == OP_TX_READY) begin
      tx_rdata <= tx_mem[tx_read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_LINE_RX && !err_any && !rx_full) begin
      rx_mem[rx_write_ptr] <= data_byte;
    end
    if (in_acc && opcode == OP_HOST_READ) begin
      rx_rdata <= rx_mem[rx_read_ptr];
    end
  end

  // per-request response flags and the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      resp_accepted  <= (opcode == OP_HOST_WRITE && !tx_full) ||
                        (opcode == OP_HOST_READ && !rx_empty);
      resp_read      <= (opcode == OP_HOST_READ) && !rx_empty;
      resp_send_tx   <= (opcode == OP_TX_READY) && !tx_empty;
      resp_send_echo <= (opcode == OP_LINE_RX) && !err_any && echo_enable;
      echo_byte      <= data_byte;
    end
    if (busy) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_uart_ring_buffer_controller_top.sv =====
// Self-checking testbench for uart_ring_buffer_controller_top: a directed set of requests,
// then random traffic phases, each checked against a behavioural model of both rings.
// Depends on urbc_pkg and the block's RTL only.

module tb_uart_ring_buffer_controller_top;
  import urbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_REQS = 100;
  localparam int unsigned REPORT_CAP = 200;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;
  localparam logic [3:0] NO_ERRORS = 4'b0000;

  typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_EVEN} traffic_t;

  // Shadow of both rings, the error counters and the irq flag.
  class uart_ring_tracker;
    logic [7:0] tx_mem[64];
    logic [7:0] rx_mem[64];
    logic [5:0] tx_wr, tx_rd, rx_wr, rx_rd;
    logic [31:0] frame_cnt, parity_cnt, noise_cnt, overrun_cnt;
    logic irq_on;
    logic echo_on;
    urbc_result_t status_due[$];
    int errors;

    function new();
      foreach (tx_mem[i]) tx_mem[i] = 8'h00;
      foreach (rx_mem[i]) rx_mem[i] = 8'h00;
      tx_wr = '0;
      tx_rd = '0;
      rx_wr = '0;
      rx_rd = '0;
      frame_cnt = '0;
      parity_cnt = '0;
      noise_cnt = '0;
      overrun_cnt = '0;
      irq_on = 1'b1;
      echo_on = 1'b0;
      errors = 0;
    endfunction

    // flags: [0] frame, [1] parity, [2] noise, [3] overrun
    function void apply_request(logic [2:0] op, logic [7:0] data, logic [3:0] flags);
      urbc_result_t r;
      logic [5:0] nxt;
      r = '0;
      case (op)
        OP_HOST_WRITE: begin
          nxt = tx_wr + 6'd1;
          if (nxt != tx_rd) begin
            tx_mem[tx_wr] = data;
            tx_wr = nxt;
            irq_on = 1'b1;
            r.accepted = 1'b1;
          end
        end
        OP_HOST_READ: begin
          if (rx_wr != rx_rd) begin
            r.read_byte = rx_mem[rx_rd];
            rx_rd = rx_rd + 6'd1;
            r.read_valid = 1'b1;
            r.accepted = 1'b1;
          end
        end
        OP_LINE_RX: begin
          if (flags[0]) frame_cnt = frame_cnt + 32'd1;
          if (flags[1]) parity_cnt = parity_cnt + 32'd1;
          if (flags[2]) noise_cnt = noise_cnt + 32'd1;
          if (flags[3]) overrun_cnt = overrun_cnt + 32'd1;
          if (flags == NO_ERRORS) begin
            // echo goes out even when the ring has no room
            if (echo_on) begin
              r.line_send_valid = 1'b1;
              r.line_send_byte = data;
            end
            nxt = rx_wr + 6'd1;
            if (nxt != rx_rd) begin
              rx_mem[rx_wr] = data;
              rx_wr = nxt;
            end
          end
        end
        OP_TX_READY: begin
          if (tx_rd == tx_wr) begin
            irq_on = 1'b0;
          end else begin
            r.line_send_byte = tx_mem[tx_rd];
            r.line_send_valid = 1'b1;
            tx_rd = tx_rd + 6'd1;
          end
        end
        OP_RX_PURGE: begin
          rx_wr = '0;
          rx_rd = '0;
        end
        default: ;
      endcase
      r.tx_free = tx_rd - tx_wr - 6'd1;
      r.rx_count = rx_wr - rx_rd;
      r.framing_errors = frame_cnt;
      r.parity_errors = parity_cnt;
      r.noise_errors = noise_cnt;
      r.overrun_errors = overrun_cnt;
      r.tx_irq_enabled = irq_on;
      status_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_status(urbc_result_t got);
      urbc_result_t want;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = status_due.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("line_send_valid", want.line_send_valid, got.line_send_valid);
      compare_field("line_send_byte", want.line_send_byte, got.line_send_byte);
      compare_field("tx_free", want.tx_free, got.tx_free);
      compare_field("rx_count", want.rx_count, got.rx_count);
      compare_field("framing_errors", want.framing_errors, got.framing_errors);
      compare_field("parity_errors", want.parity_errors, got.parity_errors);
      compare_field("noise_errors", want.noise_errors, got.noise_errors);
      compare_field("overrun_errors", want.overrun_errors, got.overrun_errors);
      compare_field("tx_irq_enabled", want.tx_irq_enabled, got.tx_irq_enabled);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  uart_ring_tracker tracker = new();
  logic steady = 1'b0;
  int sink_hold = 0;
  int unsigned cycle_count = 0;

  uart_ring_buffer_controller_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_op(traffic_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      TRAFFIC_FILL: begin
        if (r < 40) return OP_HOST_WRITE;
        if (r < 85) return OP_LINE_RX;
        if (r < 88) return OP_HOST_READ;
        if (r < 94) return OP_TX_READY;
      end
      TRAFFIC_DRAIN: begin
        if (r < 10) return OP_HOST_WRITE;
        if (r < 25) return OP_LINE_RX;
        if (r < 60) return OP_HOST_READ;
        if (r < 94) return OP_TX_READY;
        if (r < 97) return OP_RX_PURGE;
      end
      default: begin
        if (r < 22) return OP_HOST_WRITE;
        if (r < 44) return OP_LINE_RX;
        if (r < 66) return OP_HOST_READ;
        if (r < 88) return OP_TX_READY;
        if (r < 95) return OP_RX_PURGE;
      end
    endcase
    return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [7:0] data,
                              input logic [3:0] flags);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0000, flags, data};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.apply_request(op, data, flags);
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_echo(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.echo_on = value;
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure, plus one long hold when requested
  initial begin : sink
    int n;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("uart_ring_buffer_controller_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [2:0] op;
    logic [3:0] flags;
    traffic_t mix;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_HOST_WRITE;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_echo(1'b0);

    // directed: empty ring corners, byte extremes, each error flag, purge, spare codes
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);
    send_request(OP_TX_READY, 8'h00, NO_ERRORS);
    send_request(OP_HOST_WRITE, 8'h00, NO_ERRORS);
    send_request(OP_HOST_WRITE, 8'hFF, NO_ERRORS);
    send_request(OP_TX_READY, 8'h00, NO_ERRORS);
    send_request(OP_TX_READY, 8'h00, NO_ERRORS);
    send_request(OP_TX_READY, 8'h00, NO_ERRORS);
    send_request(OP_LINE_RX, 8'h00, NO_ERRORS);
    send_request(OP_LINE_RX, 8'hFF, NO_ERRORS);
    send_request(OP_LINE_RX, 8'h5A, 4'b0001);
    send_request(OP_LINE_RX, 8'h5A, 4'b0010);
    send_request(OP_LINE_RX, 8'h5A, 4'b0100);
    send_request(OP_LINE_RX, 8'h5A, 4'b1000);
    send_request(OP_LINE_RX, 8'hFF, 4'b1111);
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);
    send_request(OP_LINE_RX, 8'h3C, NO_ERRORS);
    send_request(OP_RX_PURGE, 8'h00, NO_ERRORS);
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      send_request(3'(c), 8'hFF, 4'b1111);
    wait_drained();
    write_echo(1'b1);
    send_request(OP_LINE_RX, 8'hC3, NO_ERRORS);
    send_request(OP_LINE_RX, 8'h81, 4'b0001);
    send_request(OP_HOST_READ, 8'h00, NO_ERRORS);

    // random phases, echo toggling each time; rings carry over between phases
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_echo(p[0]);
      case (p % 4)
        0, 1: mix = TRAFFIC_FILL;
        2: mix = TRAFFIC_EVEN;
        default: mix = TRAFFIC_DRAIN;
      endcase
      steady = (p == 6);
      if (p == 2) sink_hold = 400;
      for (int k = 0; k < PHASE_REQS; k++) begin
        op = pick_op(mix);
        if (op == OP_LINE_RX && $urandom_range(0, 99) < 85) flags = NO_ERRORS;
        else flags = 4'($urandom_range(0, 15));
        send_request(op, 8'($urandom_range(0, 255)), flags);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.status_due.size() == 0)
      $display("uart_ring_buffer_controller_top regression: pass");
    else
      $display("uart_ring_buffer_controller_top regression: fail");
    $finish;
  end

endmodule

// ===== uart_ring_buffer_controller_top.f =====
rtl/core/urbc_pkg.sv
rtl/core/uart_ring_buffer_controller_top.sv
test/tb_uart_ring_buffer_controller_top.sv
